// ===== src/fpfa_pkg.sv =====
package fpfa_pkg;

	localparam int NUM_PARTS  = 8;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_BITS   = $clog2(NUM_PARTS);
	localparam int CNT_BITS   = 4;
	localparam int WASTE_BITS = 19;
	localparam int MODE_BITS  = 2;
	localparam int OP_BITS    = 2;
	localparam int STAT_BITS  = 2;
	localparam int IN_BITS    = 24;
	localparam int OUT_BITS   = 40;

	// opcodes
	localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_BITS-1:0] OP_PLACE = 2'd1;
	localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

	// result status codes
	localparam logic [STAT_BITS-1:0] ST_DONE   = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_PLACED = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_WAIT   = 2'd2;
	localparam logic [STAT_BITS-1:0] ST_BAD    = 2'd3;

	// fit modes
	localparam logic [MODE_BITS-1:0] FIT_FIRST = 2'd0;
	localparam logic [MODE_BITS-1:0] FIT_NEXT  = 2'd1;
	localparam logic [MODE_BITS-1:0] FIT_BEST  = 2'd2;

	// config register indexes
	localparam logic REG_FIT_MODE   = 1'b0;
	localparam logic REG_PART_COUNT = 1'b1;

	localparam logic [CNT_BITS-1:0] COUNT_RESET = 4'd8;

	typedef struct packed {
		logic latch;    // capture accepted item
		logic apply;    // load/clear write, scan setup
		logic step;     // visit one partition
		logic commit;   // placement write, form result
		logic publish;  // move result to output register
	} fpfa_cmd_t;

	typedef struct packed {
		logic scan_last;
	} fpfa_stat_t;

endpackage

// ===== src/fpfa_ctrl.sv =====
module fpfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  fpfa_pkg::fpfa_stat_t stat,
	output fpfa_pkg::fpfa_cmd_t  cmd
);
	import fpfa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APPLY,
		S_SCAN,
		S_COMMIT,
		S_DONE
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd         = '0;
		cmd.latch   = (state_q == S_IDLE) && s_tvalid;
		cmd.apply   = (state_q == S_APPLY);
		cmd.step    = (state_q == S_SCAN);
		cmd.commit  = (state_q == S_COMMIT);
		cmd.publish = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (cmd.publish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY:  state_q <= S_SCAN;
				S_SCAN: begin
					if (stat.scan_last) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/fpfa_dp.sv =====
module fpfa_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [fpfa_pkg::IN_BITS-1:0]   s_tdata,
	output logic [fpfa_pkg::OUT_BITS-1:0]  m_tdata,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [fpfa_pkg::CNT_BITS-1:0]  cfg_data,
	input  fpfa_pkg::fpfa_cmd_t            cmd,
	output fpfa_pkg::fpfa_stat_t           stat
);
	import fpfa_pkg::*;

	// configuration
	logic [MODE_BITS-1:0] fit_mode_q;
	logic [CNT_BITS-1:0]  part_count_q;

	// partition table
	logic [SIZE_BITS-1:0] part_size_q [NUM_PARTS];
	logic [SIZE_BITS-1:0] held_size_q [NUM_PARTS];
	logic [NUM_PARTS-1:0] used_q;
	logic [IDX_BITS-1:0]  next_start_q;

	// current item
	logic [OP_BITS-1:0]   op_q;
	logic [IDX_BITS-1:0]  idx_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [CNT_BITS-1:0]  n_q;

	// scan
	logic [IDX_BITS-1:0]   ptr_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  found_q;
	logic [IDX_BITS-1:0]   best_q;
	logic [SIZE_BITS-1:0]  best_size_q;
	logic [WASTE_BITS-1:0] acc_q;

	// result
	logic [STAT_BITS-1:0]  res_status_q;
	logic [IDX_BITS-1:0]   res_chosen_q;
	logic [SIZE_BITS-1:0]  res_job_waste_q;
	logic [WASTE_BITS-1:0] res_total_q;
	logic [OUT_BITS-1:0]   out_q;

	logic [CNT_BITS-1:0]  n_in;
	logic                 bad;
	logic                 load_ok;
	logic                 place_ok;
	logic [SIZE_BITS-1:0] cur_size;
	logic [SIZE_BITS-1:0] contrib;
	logic                 fits;
	logic                 take;
	logic                 is_best;
	logic [IDX_BITS-1:0]  start_idx;
	logic [CNT_BITS-1:0]  best_inc;

	always_comb begin
		if (part_count_q == '0) begin
			n_in = CNT_BITS'(1);
		end else if (part_count_q > CNT_BITS'(NUM_PARTS)) begin
			n_in = CNT_BITS'(NUM_PARTS);
		end else begin
			n_in = part_count_q;
		end
	end

	always_comb begin
		load_ok  = (op_q == OP_LOAD) && ({1'b0, idx_q} < n_q);
		place_ok = (op_q == OP_PLACE) && (size_q != '0);
		bad      = !(load_ok || place_ok || (op_q == OP_CLEAR));
	end

	assign is_best   = (fit_mode_q == FIT_BEST);
	assign start_idx = ((fit_mode_q == FIT_NEXT) && ({1'b0, next_start_q} < n_q))
		? next_start_q : '0;

	always_comb begin
		cur_size = part_size_q[ptr_q];
		contrib  = used_q[ptr_q] ? (cur_size - held_size_q[ptr_q]) : cur_size;
		fits     = !used_q[ptr_q] && (cur_size >= size_q);
		take     = fits && (!found_q || (is_best && (cur_size < best_size_q)));
	end

	assign best_inc       = {1'b0, best_q} + CNT_BITS'(1);
	assign stat.scan_last = (cnt_q == n_q - CNT_BITS'(1));
	assign m_tdata        = out_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q   <= FIT_FIRST;
			part_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIT_MODE:   fit_mode_q   <= cfg_data[MODE_BITS-1:0];
				REG_PART_COUNT: part_count_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// partition table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PARTS; i++) begin
				part_size_q[i] <= '0;
				held_size_q[i] <= '0;
			end
			used_q       <= '0;
			next_start_q <= '0;
		end else begin
			if (cmd.apply && load_ok) begin
				part_size_q[idx_q] <= size_q;
				held_size_q[idx_q] <= '0;
				used_q[idx_q]      <= 1'b0;
			end
			if (cmd.apply && (op_q == OP_CLEAR)) begin
				for (int i = 0; i < NUM_PARTS; i++) begin
					held_size_q[i] <= '0;
				end
				used_q       <= '0;
				next_start_q <= '0;
			end
			if (cmd.commit && place_ok && found_q) begin
				used_q[best_q]      <= 1'b1;
				held_size_q[best_q] <= size_q;
				next_start_q        <= (best_inc < n_q) ? best_inc[IDX_BITS-1:0] : '0;
			end
		end
	end

	// item capture, scan and result
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= s_tdata[OP_BITS-1:0];
			idx_q  <= s_tdata[OP_BITS +: IDX_BITS];
			size_q <= s_tdata[OP_BITS+IDX_BITS +: SIZE_BITS];
			n_q    <= n_in;
		end
		if (cmd.apply) begin
			ptr_q   <= start_idx;
			cnt_q   <= '0;
			found_q <= 1'b0;
			acc_q   <= '0;
		end
		if (cmd.step) begin
			acc_q <= acc_q + WASTE_BITS'(contrib);
			cnt_q <= cnt_q + CNT_BITS'(1);
			ptr_q <= ({1'b0, ptr_q} == n_q - CNT_BITS'(1)) ? '0 : ptr_q + IDX_BITS'(1);
			if (take) begin
				found_q     <= 1'b1;
				best_q      <= ptr_q;
				best_size_q <= cur_size;
			end
		end
		if (cmd.commit) begin
			res_total_q     <= acc_q;
			res_chosen_q    <= '0;
			res_job_waste_q <= '0;
			if (bad) begin
				res_status_q <= ST_BAD;
			end else if (op_q != OP_PLACE) begin
				res_status_q <= ST_DONE;
			end else if (found_q) begin
				res_status_q    <= ST_PLACED;
				res_chosen_q    <= best_q;
				res_job_waste_q <= best_size_q - size_q;
				// the chosen partition turns from free size into internal waste
				res_total_q     <= acc_q - WASTE_BITS'(size_q);
			end else begin
				res_status_q <= ST_WAIT;
			end
		end
		if (cmd.publish) begin
			out_q <= {res_total_q, res_job_waste_q, res_chosen_q, res_status_q};
		end
	end

endmodule

// ===== src/fixed_partition_fit_allocator_unit.sv =====
// from input transfer to m_tvalid high: apply, scan of the active partitions (1..8),
// commit, then done until the output register is free; one partition scanned per cycle
// the next input transfer is taken while a finished result waits in the output register
// reset (arst_n low, asynchronous): all partitions size zero and free, next-fit start 0,
// fit mode first fit, partition count 8, no result pending
module fixed_partition_fit_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [1:0] opcode, [4:2] part_index, [20:5] item_size, [23:21] zero
	input  logic [fpfa_pkg::IN_BITS-1:0]  s_tdata,
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [1:0] status, [4:2] chosen_partition, [20:5] job_waste, [39:21] total_waste
	output logic [fpfa_pkg::OUT_BITS-1:0] m_tdata,
	// configuration writes: index 0 fit_mode, index 1 partition_count
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [fpfa_pkg::CNT_BITS-1:0] cfg_data
);
	import fpfa_pkg::*;

	// command and status between sequencer and datapath
	fpfa_cmd_t  cmd;
	fpfa_stat_t stat;

	// sequencer: idle -> apply (load/clear write) -> scan n partitions
	// -> commit placement -> hand result to output register
	fpfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: partition table, scan pointer, fit tracking, waste sum, result registers
	fpfa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== tb/sv/tb_fixed_partition_fit_allocator_unit.sv =====
module tb_fixed_partition_fit_allocator_unit;
	import fpfa_pkg::*;

	// timing and run length
	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = NUM_PARTS + 8;   // longest item, with all partitions active, plus margin
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 72;
	localparam int HOLD_OFF_LEN  = 300;

	// codes with no name in the package
	localparam logic [OP_BITS-1:0]   OP_SPARE       = 2'd3;   // undefined opcode
	localparam logic [MODE_BITS-1:0] FIT_MODE_SPARE = 2'd3;   // behaves as first fit

	// one result item, unpacked from m_tdata
	typedef struct packed {
		logic [STAT_BITS-1:0]  status;
		logic [IDX_BITS-1:0]   part;
		logic [SIZE_BITS-1:0]  job_waste;
		logic [WASTE_BITS-1:0] total_waste;
	} alloc_result_t;

	// dut pins, the testbench-driven ones known from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_BITS-1:0]    s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_BITS-1:0]   m_tdata;
	logic                  cfg_we    = 1'b0;
	logic                  cfg_index = 1'b0;
	logic [CNT_BITS-1:0]   cfg_data  = '0;

	// allocator image kept by the testbench
	logic [SIZE_BITS-1:0] slot_size [NUM_PARTS] = '{default: '0};
	logic [SIZE_BITS-1:0] slot_held [NUM_PARTS] = '{default: '0};
	logic                 slot_busy [NUM_PARTS] = '{default: 1'b0};
	int                   next_fit_start = 0;
	logic [MODE_BITS-1:0] fit_rule       = FIT_FIRST;
	logic [CNT_BITS-1:0]  part_limit     = COUNT_RESET;

	// results still owed by the block, oldest first
	alloc_result_t pending_results [$];
	alloc_result_t seen_result;
	alloc_result_t owed_result;

	// bookkeeping
	int error_count     = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int placed_count    = 0;
	int waiting_count   = 0;
	int reg_writes      = 0;
	int cycle_count     = 0;

	// idling control: idle_on shared by sender and receiver, hold-off and gap for the receiver
	bit idle_on         = 1'b0;
	int hold_off_cycles = 0;
	int ready_gap       = 0;

	always #CLK_HALF clk = ~clk;

	fixed_partition_fit_allocator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ---------------------------------------------------------------
	// allocator prediction
	// ---------------------------------------------------------------

	// partition count register clamped to 1..NUM_PARTS
	function automatic int active_parts();
		int n;
		n = int'(part_limit);
		if (n == 0)
			n = 1;
		if (n > NUM_PARTS)
			n = NUM_PARTS;
		return n;
	endfunction

	function automatic bit slot_fits(int k, logic [SIZE_BITS-1:0] job);
		return !slot_busy[k] && slot_size[k] >= job;
	endfunction

	// applies one accepted item to the image and returns the result it owes
	function automatic alloc_result_t predict_alloc(logic [OP_BITS-1:0] op,
			logic [IDX_BITS-1:0] idx, logic [SIZE_BITS-1:0] size);
		alloc_result_t          r;
		int                     n;
		int                     pick;
		int                     start;
		int                     k;
		logic [SIZE_BITS-1:0]   slack;
		logic [WASTE_BITS-1:0]  sum;
		n = active_parts();
		r = '0;
		r.status = ST_BAD;
		case (op)
			OP_LOAD: begin
				// loading frees the partition, dropping any job held there
				if (int'(idx) < n) begin
					slot_size[idx] = size;
					slot_held[idx] = '0;
					slot_busy[idx] = 1'b0;
					r.status = ST_DONE;
				end
			end
			OP_PLACE: begin
				if (size != '0) begin
					pick = n;
					if (fit_rule == FIT_NEXT) begin
						// stale start at or past the count restarts at zero
						start = (next_fit_start < n) ? next_fit_start : 0;
						for (int i = 0; i < n; i++) begin
							k = start + i;
							if (k >= n)
								k = k - n;
							if (slot_fits(k, size)) begin
								pick = k;
								break;
							end
						end
					end else begin
						// first fit, also for the spare mode; best fit keeps lowest on ties
						for (int i = 0; i < n; i++) begin
							if (slot_fits(i, size)) begin
								if (fit_rule != FIT_BEST) begin
									pick = i;
									break;
								end
								if (pick == n || slot_size[i] < slot_size[pick])
									pick = i;
							end
						end
					end
					if (pick < n) begin
						slot_busy[pick] = 1'b1;
						slot_held[pick] = size;
						next_fit_start = (pick + 1 < n) ? pick + 1 : 0;
						r.status = ST_PLACED;
						r.part = pick[IDX_BITS-1:0];
						r.job_waste = slot_size[pick] - size;
						placed_count++;
					end else begin
						r.status = ST_WAIT;
						waiting_count++;
					end
				end
			end
			OP_CLEAR: begin
				// every partition freed, sizes kept, also those beyond the count
				for (int i = 0; i < NUM_PARTS; i++) begin
					slot_busy[i] = 1'b0;
					slot_held[i] = '0;
				end
				next_fit_start = 0;
				r.status = ST_DONE;
			end
			default: ;
		endcase
		// free active partitions count whole, occupied ones their slack
		sum = '0;
		for (int i = 0; i < n; i++) begin
			slack = slot_busy[i] ? slot_size[i] - slot_held[i] : slot_size[i];
			sum = sum + WASTE_BITS'(slack);
		end
		r.total_waste = sum;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// idling
	// ---------------------------------------------------------------

	// mostly short gaps, now and then a long one
	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int sender_gap();
		if (!idle_on || $urandom_range(0, 99) < 40)
			return 0;
		return stall_len();
	endfunction

	// result side ready, with its own hold-off counter
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			m_tready <= 1'b0;
			hold_off_cycles = hold_off_cycles - 1;
		end else if (ready_gap > 0) begin
			m_tready <= 1'b0;
			ready_gap = ready_gap - 1;
		end else if (idle_on && $urandom_range(0, 99) < 30) begin
			m_tready <= 1'b0;
			ready_gap = stall_len() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// every result transfer is matched against the oldest owed result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_result.status      = m_tdata[1:0];
			seen_result.part        = m_tdata[4:2];
			seen_result.job_waste   = m_tdata[20:5];
			seen_result.total_waste = m_tdata[39:21];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				error_count++;
			end else begin
				owed_result = pending_results.pop_front();
				check_field("status", 32'(owed_result.status), 32'(seen_result.status));
				check_field("chosen_partition", 32'(owed_result.part),
					32'(seen_result.part));
				check_field("job_waste", 32'(owed_result.job_waste),
					32'(seen_result.job_waste));
				check_field("total_waste", 32'(owed_result.total_waste),
					32'(seen_result.total_waste));
				results_checked++;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus primitives
	// ---------------------------------------------------------------

	// offers one item, returns in the step of its transfer with tvalid still high
	task automatic send_item(input logic [OP_BITS-1:0] op, input logic [IDX_BITS-1:0] idx,
			input logic [SIZE_BITS-1:0] size);
		int            gap;
		alloc_result_t owed;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, size, idx, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		owed = predict_alloc(op, idx, size);
		pending_results.insert(pending_results.size(), owed);
		items_sent++;
	endtask

	// stop offering and wait until every owed result has arrived
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only with the block idle
	task automatic set_reg(input logic idx, input logic [CNT_BITS-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FIT_MODE)
			fit_rule = value[MODE_BITS-1:0];
		else
			part_limit = value;
		reg_writes++;
	endtask

	function automatic logic [SIZE_BITS-1:0] load_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return SIZE_BITS'($urandom_range(1, 2000));
		else if (r < 80)
			return SIZE_BITS'($urandom);
		else if (r < 90)
			return '0;
		return '1;
	endfunction

	// mostly place jobs sized around existing partitions so fits and near misses happen
	task automatic send_random_item();
		int                   r;
		int                   p;
		int                   n;
		logic [SIZE_BITS-1:0] s;
		logic [IDX_BITS-1:0]  idx;
		n = active_parts();
		r = $urandom_range(0, 99);
		idx = IDX_BITS'($urandom_range(0, 7));
		if (r < 30) begin
			// loads mostly in range, some past the count
			if ($urandom_range(0, 9) < 8)
				idx = IDX_BITS'($urandom_range(0, n - 1));
			send_item(OP_LOAD, idx, load_size());
		end else if (r < 88) begin
			p = $urandom_range(0, n - 1);
			s = slot_size[p];
			r = $urandom_range(0, 99);
			if (r < 35)
				s = (s > SIZE_BITS'(3)) ? s - SIZE_BITS'($urandom_range(0, 3)) : s;
			else if (r < 45)
				s = s + SIZE_BITS'(1);
			else if (r < 70)
				s = SIZE_BITS'($urandom_range(1, 255));
			else if (r < 90)
				s = SIZE_BITS'($urandom);
			else if (r < 95)
				s = '0;
			else
				s = '1;
			send_item(OP_PLACE, idx, s);
		end else if (r < 95) begin
			send_item(OP_CLEAR, idx, SIZE_BITS'($urandom));
		end else begin
			send_item(OP_SPARE, idx, SIZE_BITS'($urandom));
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// defaults after reset: first fit over eight partitions, all size zero
	task automatic test_reset_defaults();
		send_item(OP_PLACE, 3'd0, 16'd1);        // nothing fits a zero-size partition
		send_item(OP_PLACE, 3'd7, 16'd0);        // zero job is a bad request
		send_item(OP_SPARE, 3'd5, 16'hFFFF);     // undefined opcode
		send_item(OP_LOAD, 3'd7, 16'hFFFF);
		send_item(OP_LOAD, 3'd0, 16'd0);         // zero-size load is allowed
		send_item(OP_LOAD, 3'd2, 16'd100);
		send_item(OP_PLACE, 3'd0, 16'hFFFF);     // exact fit in the largest
		send_item(OP_PLACE, 3'd0, 16'd100);
		send_item(OP_LOAD, 3'd7, 16'd1);         // reload drops the job held there
		send_item(OP_CLEAR, 3'd0, 16'd0);
	endtask

	// next fit walks on from the last placement
	task automatic test_next_fit();
		set_reg(REG_FIT_MODE, {2'b00, FIT_NEXT});
		send_item(OP_LOAD, 3'd1, 16'd50);
		send_item(OP_LOAD, 3'd4, 16'd50);
		send_item(OP_PLACE, 3'd0, 16'd10);
		send_item(OP_PLACE, 3'd0, 16'd10);
		send_item(OP_PLACE, 3'd0, 16'd10);
	endtask

	// best fit picks the tightest, lowest index on equal sizes; upper data bits ignored
	task automatic test_best_fit();
		set_reg(REG_FIT_MODE, {2'b11, FIT_BEST});
		send_item(OP_CLEAR, 3'd0, 16'd0);
		send_item(OP_PLACE, 3'd0, 16'd40);
		send_item(OP_PLACE, 3'd0, 16'd60);
		send_item(OP_PLACE, 3'd0, 16'd1);
	endtask

	// partition count extremes, spare fit mode and a stale next-fit start
	task automatic test_count_limits();
		set_reg(REG_PART_COUNT, 4'd0);           // acts as one partition
		send_item(OP_LOAD, 3'd1, 16'd9);         // index past the count
		send_item(OP_LOAD, 3'd0, 16'd9);
		send_item(OP_PLACE, 3'd0, 16'd9);
		set_reg(REG_PART_COUNT, 4'd15);          // acts as eight
		send_item(OP_PLACE, 3'd0, 16'd1);
		set_reg(REG_FIT_MODE, {2'b10, FIT_MODE_SPARE});
		send_item(OP_PLACE, 3'd0, 16'd1);
		set_reg(REG_FIT_MODE, {2'b01, FIT_NEXT});
		send_item(OP_CLEAR, 3'd0, 16'd0);
		send_item(OP_LOAD, 3'd5, 16'd700);
		send_item(OP_PLACE, 3'd0, 16'd700);     // leaves the next-fit start at six
		set_reg(REG_PART_COUNT, 4'd3);
		send_item(OP_PLACE, 3'd0, 16'd5);       // start past the count restarts at zero
	endtask

	// long result hold-off fills the block, then a pause until all results are back
	task automatic test_output_stall();
		idle_on = 1'b0;
		set_reg(REG_PART_COUNT, COUNT_RESET);
		hold_off_cycles = HOLD_OFF_LEN;
		repeat (16) send_random_item();
		wait_drained();
		repeat (8) send_random_item();
		idle_on = 1'b1;
	endtask

	// phases of random traffic, each under its own mode and count
	task automatic test_random_traffic();
		logic [MODE_BITS-1:0] mode_cycle [4];
		logic [CNT_BITS-1:0]  count;
		logic [1:0]           junk;
		mode_cycle = '{FIT_FIRST, FIT_NEXT, FIT_BEST, FIT_MODE_SPARE};
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0:       count = 4'd8;
				1:       count = 4'd1;
				2:       count = 4'd0;
				3:       count = 4'd15;
				4:       count = 4'd3;
				default: count = CNT_BITS'($urandom_range(0, 15));
			endcase
			junk = 2'($urandom_range(0, 3));
			set_reg(REG_FIT_MODE, {junk, mode_cycle[phase % 4]});
			set_reg(REG_PART_COUNT, count);
			// some phases run with no idling at all
			idle_on = (phase % 3) != 1;
			// fill the active partitions first so placements get somewhere
			for (int i = 0; i < active_parts(); i++)
				send_item(OP_LOAD, i[IDX_BITS-1:0], load_size());
			repeat (PHASE_ITEMS) send_random_item();
		end
		idle_on = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// run control
	// ---------------------------------------------------------------

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		test_reset_defaults();
		test_next_fit();
		test_best_fit();
		test_count_limits();
		test_output_stall();
		test_random_traffic();
		wait_drained();
		$display("covered %0d input transfers, %0d results checked (%0d placed, %0d waiting)",
			items_sent, results_checked, placed_count, waiting_count);
		$display("%0d register writes over all fit modes and counts, with long output hold-off",
			reg_writes);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog on a cycle counter
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d results still owed", $time, cycle_count,
			pending_results.size());
		$display("status: fail");
		$finish;
	end

endmodule

// ===== fixed_partition_fit_allocator_unit.f =====
src/fpfa_pkg.sv
src/fpfa_ctrl.sv
src/fpfa_dp.sv
src/fixed_partition_fit_allocator_unit.sv
tb/sv/tb_fixed_partition_fit_allocator_unit.sv
